/* hdl/blm_pkg.sv */
// Package for the battery level monitor: widths, constants, config types and helpers.
package blm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MV_W = 16;
    localparam int LEVEL_W = 3;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_THR = 5;

    localparam int DEFAULT_SAMPLES_PER_WINDOW = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam int MV_GAIN = 36381;
    localparam int MV_GAIN_W = 16;
    localparam int MV_OFFSET = 2216;
    localparam int MV_SHIFT = 12;
    localparam int MV_WRAP_W = 32;
    localparam int MV_STEP = 100;
    localparam int STEP_RECIP = (1 << MV_W) / MV_STEP;
    localparam int STEP_RECIP_W = $clog2(STEP_RECIP + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(5);

    localparam logic [CFG_W-1:0] THR0_RST = CFG_W'(3300);
    localparam logic [CFG_W-1:0] THR1_RST = CFG_W'(3500);
    localparam logic [CFG_W-1:0] THR2_RST = CFG_W'(3650);
    localparam logic [CFG_W-1:0] THR3_RST = CFG_W'(3800);
    localparam logic [CFG_W-1:0] THR4_RST = CFG_W'(3950);
    localparam logic [CFG_W-1:0] HYST_RST = CFG_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL0_THR,
        REG_LEVEL1_THR,
        REG_LEVEL2_THR,
        REG_LEVEL3_THR,
        REG_LEVEL4_THR,
        REG_HYST
    } cfg_idx_t;

    typedef struct packed {
        logic [NUM_THR-1:0][CFG_W-1:0] thr;
        logic [CFG_W-1:0]              hyst;
    } cfg_t;

    function automatic logic [CFG_W-1:0] thr_at(input cfg_t c, input logic [LEVEL_W-1:0] i);
        logic [CFG_W-1:0] t;
        begin
            unique case (i)
                LEVEL_W'(0): t = c.thr[0];
                LEVEL_W'(1): t = c.thr[1];
                LEVEL_W'(2): t = c.thr[2];
                LEVEL_W'(3): t = c.thr[3];
                LEVEL_W'(4): t = c.thr[4];
                default:     t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

/* hdl/blm_front.sv */
// Front end: accepts samples, skips the window head and accumulates the window sum.
module blm_front
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_WINDOW = DEFAULT_SAMPLES_PER_WINDOW,
    parameter int SUM_W = SAMPLE_W + $clog2(DEFAULT_SAMPLES_PER_WINDOW - 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                q_full,
    output logic                q_push,
    output logic [SUM_W-1:0]    q_sum
);

    localparam int IDX_W = $clog2(SAMPLES_PER_WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_WINDOW - 1);
    localparam logic [IDX_W-1:0] FIRST_KEPT = IDX_W'(2);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] sum_add;
    logic             accept;
    logic             last;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign last     = (idx_reg == LAST_IDX);
    assign sum_add  = (idx_reg >= FIRST_KEPT) ? sum_reg + SUM_W'(sample) : sum_reg;
    assign q_push   = accept && last;
    assign q_sum    = sum_add;

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (last)
            begin
                idx_next = '0;
                sum_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("window index out of range");
    a_head_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= FIRST_KEPT) |-> (sum_reg == '0))
        else $error("sum not clear at window head");
    a_push_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (idx_reg == '0))
        else $error("index did not wrap after window close");
`endif

endmodule

/* hdl/blm_queue.sv */
// Short queue of finished window sums between front and back.
module blm_queue
    import blm_pkg::*;
#(
    parameter int DATA_W = SAMPLE_W + $clog2(DEFAULT_SAMPLES_PER_WINDOW - 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == DEPTH_C);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers inconsistent with count");
`endif

endmodule

/* hdl/blm_back.sv */
// Back end: rounded average, millivolt conversion, 100 mV truncation and level classification.
module blm_back
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_WINDOW = DEFAULT_SAMPLES_PER_WINDOW,
    parameter int SUM_W = SAMPLE_W + $clog2(DEFAULT_SAMPLES_PER_WINDOW - 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  logic [SUM_W-1:0]   q_sum,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MV_W-1:0]    voltage_mv,
    output logic [LEVEL_W-1:0] level
);

    localparam int COUNT = SAMPLES_PER_WINDOW - 2;
    localparam int HALF = COUNT / 2;
    localparam int XW = SUM_W + 1;
    localparam int RW = XW + 1;
    localparam int PW = XW + RW;
    localparam logic [RW-1:0] RECIP_C = RW'((64'd1 << XW) / COUNT);
    localparam int MUL_W = SAMPLE_W + MV_GAIN_W;
    localparam int P100_W = MV_W + STEP_RECIP_W;
    localparam int Q100_W = P100_W - MV_W;
    localparam int STAGES = 5;

    logic                 en;
    logic [STAGES-1:0]    vld_reg, vld_next;

    logic [XW-1:0]        x1;
    logic [PW-1:0]        prod1;
    logic [XW-1:0]        x_reg;
    logic [PW-1:0]        prod_reg;

    logic [RW-1:0]        q0;
    logic [XW-1:0]        qc0;
    logic [XW-1:0]        r0;
    logic [SAMPLE_W-1:0]  avg2;
    logic [SAMPLE_W-1:0]  avg_reg;

    logic [MUL_W-1:0]     t3;
    logic [MUL_W-1:0]     t_reg;

    logic [MV_WRAP_W-1:0] diff4;
    logic [MV_W-1:0]      mv4;
    logic [P100_W-1:0]    p4;
    logic [MV_W-1:0]      mv4_reg;
    logic [P100_W-1:0]    p_reg;

    logic [Q100_W-1:0]    q5;
    logic [MV_W-1:0]      qc5;
    logic [MV_W-1:0]      r5;
    logic [MV_W-1:0]      a5;
    logic [MV_W-1:0]      mv5_reg;
    logic [MV_W-1:0]      a_reg;

    logic [LEVEL_W-1:0]   band;
    logic [LEVEL_W-1:0]   lvl6;
    logic [CFG_W-1:0]     thr_hi;
    logic [CFG_W-1:0]     thr_lo;

    logic                 out_v_reg, out_v_next;
    logic [MV_W-1:0]      out_mv_reg;
    logic [LEVEL_W-1:0]   out_lvl_reg;
    logic [LEVEL_W-1:0]   prev_reg, prev_next;

    assign en       = !(out_v_reg && !out_ready);
    assign q_pop    = en && !q_empty;
    assign vld_next = {vld_reg[STAGES-2:0], q_pop};

    // window average: reciprocal estimate, then one correction step
    assign x1    = XW'(q_sum) + XW'(HALF);
    assign prod1 = PW'(x1) * PW'(RECIP_C);

    assign q0   = prod_reg[PW-1:XW];
    assign qc0  = XW'(PW'(q0) * PW'(COUNT));
    assign r0   = x_reg - qc0;
    assign avg2 = SAMPLE_W'(q0) + SAMPLE_W'(r0 >= XW'(COUNT));

    assign t3 = MUL_W'(avg_reg) * MUL_W'(MV_GAIN);

    assign diff4 = MV_WRAP_W'(t_reg) - MV_WRAP_W'(MV_OFFSET);
    assign mv4   = diff4[MV_SHIFT +: MV_W];
    assign p4    = P100_W'(mv4) * P100_W'(STEP_RECIP);

    // truncate to a 100 mV step
    assign q5  = p_reg[P100_W-1:MV_W];
    assign qc5 = MV_W'(MV_W'(q5) * MV_W'(MV_STEP));
    assign r5  = mv4_reg - qc5;
    assign a5  = (r5 >= MV_W'(MV_STEP)) ? qc5 + MV_W'(MV_STEP) : qc5;

    always_comb
    begin
        band = '0;
        for (int b = 0; b < NUM_THR; b++)
        begin
            if (a_reg >= cfg.thr[b])
            begin
                band = LEVEL_W'(b + 1);
            end
        end
    end

    assign thr_hi = thr_at(cfg, band);
    assign thr_lo = thr_at(cfg, band - LEVEL_W'(1));

    always_comb
    begin
        priority if (band < LEVEL_MAX && prev_reg == band + LEVEL_W'(1))
        begin
            lvl6 = ({1'b0, a_reg} + {1'b0, cfg.hyst} < {1'b0, thr_hi}) ? band : prev_reg;
        end
        else if (band > '0 && prev_reg == band - LEVEL_W'(1))
        begin
            lvl6 = ({1'b0, a_reg} >= {1'b0, thr_lo} + {1'b0, cfg.hyst}) ? band : prev_reg;
        end
        else
        begin
            lvl6 = band;
        end
    end

    always_comb
    begin
        out_v_next = out_v_reg && !out_ready;
        prev_next  = prev_reg;
        if (en)
        begin
            out_v_next = vld_reg[STAGES-1];
            if (vld_reg[STAGES-1])
            begin
                prev_next = lvl6;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x1;
            prod_reg    <= prod1;
            avg_reg     <= avg2;
            t_reg       <= t3;
            mv4_reg     <= mv4;
            p_reg       <= p4;
            mv5_reg     <= mv4_reg;
            a_reg       <= a5;
            out_mv_reg  <= mv5_reg;
            out_lvl_reg <= lvl6;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
            prev_reg  <= LEVEL_MAX;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= vld_next;
            end
            out_v_reg <= out_v_next;
            prev_reg  <= prev_next;
        end
    end

    assign out_valid  = out_v_reg;
    assign voltage_mv = out_mv_reg;
    assign level      = out_lvl_reg;

`ifndef ASSERT_OFF
    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg <= LEVEL_MAX)
        else $error("previous level out of range");
    a_out_is_prev: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_lvl_reg == prev_reg))
        else $error("held level differs from stored previous level");
    a_stall_holds_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready) |=> $stable(prev_reg))
        else $error("previous level changed during stall");
    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready) |-> !q_pop)
        else $error("queue popped while output stalled");
`endif

endmodule

/* hdl/battery_level_monitor.sv */
// Top level of the battery level monitor: ports, config registers, front/queue/back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[11:0] sample
//  m_*      out  m_tvalid/m_tready  m_tdata[15:0] voltage_mv, [18:16] level
//  cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// One sample request accepted per cycle; s_tready drops only when the window queue is full.
// A result becomes valid once the last sample of a window passes the queue, 5 stages and the output reg.
// Throughput set by the front accumulator: one sample per clock while the queue is not full, one result per window.
// Reset: window index and sum cleared, previous level 5, registers to defaults.
// A stalled result holds the back pipeline; the front keeps accepting into the queue until it is full.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_WINDOW = DEFAULT_SAMPLES_PER_WINDOW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [11:0] sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [15:0] voltage_mv, [18:16] level
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_WINDOW - 1);

    cfg_t               cfg_reg;
    logic               q_push;
    logic [SUM_W-1:0]   q_push_data;
    logic               q_full;
    logic               q_pop;
    logic [SUM_W-1:0]   q_pop_data;
    logic               q_empty;
    logic [MV_W-1:0]    voltage_mv;
    logic [LEVEL_W-1:0] level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr[0] <= THR0_RST;
            cfg_reg.thr[1] <= THR1_RST;
            cfg_reg.thr[2] <= THR2_RST;
            cfg_reg.thr[3] <= THR3_RST;
            cfg_reg.thr[4] <= THR4_RST;
            cfg_reg.hyst   <= HYST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LEVEL0_THR: cfg_reg.thr[0] <= cfg_data;
                REG_LEVEL1_THR: cfg_reg.thr[1] <= cfg_data;
                REG_LEVEL2_THR: cfg_reg.thr[2] <= cfg_data;
                REG_LEVEL3_THR: cfg_reg.thr[3] <= cfg_data;
                REG_LEVEL4_THR: cfg_reg.thr[4] <= cfg_data;
                REG_HYST:       cfg_reg.hyst   <= cfg_data;
                default:        cfg_reg        <= cfg_reg;
            endcase
        end
    end

    blm_front #(
        .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW),
        .SUM_W(SUM_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .sample(s_tdata[SAMPLE_W-1:0]),
        .q_full(q_full),
        .q_push(q_push),
        .q_sum(q_push_data)
    );

    blm_queue #(
        .DATA_W(SUM_W)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(q_push_data),
        .full(q_full),
        .pop(q_pop),
        .pop_data(q_pop_data),
        .empty(q_empty)
    );

    blm_back #(
        .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW),
        .SUM_W(SUM_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_empty(q_empty),
        .q_sum(q_pop_data),
        .q_pop(q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .voltage_mv(voltage_mv),
        .level(level)
    );

    assign m_tdata = {5'b0, level, voltage_mv};

endmodule
